### design/pwmsetup_pkg.sv
// Shared constants, command codes and prescaler table of the PWM setup engine.
package pwmsetup_pkg;

  localparam int unsigned COUNTER_BITS_DEF = 16;

  localparam int unsigned CLK_W     = 27;
  localparam int unsigned FREQ_W    = 28;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CH_W      = 2;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned SDUTY_W   = 15;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned SHIFT_W   = 4;

  // clock_hz * 256 and prescale * freq_q8.
  localparam int unsigned N_W       = CLK_W + 8;
  localparam int unsigned D_W       = FREQ_W + 10;
  // Divider operand widths: 2N - D for the top, 2D as its divisor.
  localparam int unsigned NUM_W     = N_W + 1;
  localparam int unsigned DEN_W     = D_W + 1;

  localparam logic [CLK_W-1:0]   CLOCK_RESET = CLK_W'(16000000);
  localparam logic [SDUTY_W-1:0] DUTY_FULL   = SDUTY_W'(25600);
  localparam logic [NUM_W-1:0]   ROUND_HALF  = NUM_W'(25600);
  localparam logic [DEN_W-1:0]   CMP_DEN     = DEN_W'(51200);

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DUTY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  localparam logic [IDX_W-1:0] PRESC_LAST = 3'd4;

  // Shift that multiplies by the prescaler 1, 8, 64, 256 or 1024.
  function automatic logic [SHIFT_W-1:0] presc_shift(input logic [IDX_W-1:0] idx);
    logic [SHIFT_W-1:0] sh;
    case (idx)
      3'd0:    sh = 4'd0;
      3'd1:    sh = 4'd3;
      3'd2:    sh = 4'd6;
      3'd3:    sh = 4'd8;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

### design/pwmsetup_div.sv
// Restoring divider, one quotient bit per cycle, shared by the setup sequencer.
module pwmsetup_div #(
  parameter int unsigned CB    = pwmsetup_pkg::COUNTER_BITS_DEF,
  parameter int unsigned NUM_W = pwmsetup_pkg::NUM_W,
  parameter int unsigned DEN_W = pwmsetup_pkg::DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [CB-1:0]    quot_o
);

  localparam int unsigned DV_W  = DEN_W + CB - 1;
  localparam int unsigned CNT_W = $clog2(CB + 1);

  logic [NUM_W-1:0] rem_q, rem_d;
  logic [DV_W-1:0]  dv_q, dv_d;
  logic [CB-1:0]    quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DV_W-1:0]  rem_ext;
  logic [DV_W-1:0]  diff;
  logic             ge;

  assign rem_ext = DV_W'(rem_q);
  assign diff    = rem_ext - dv_q;
  assign ge      = rem_ext >= dv_q;

  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (ge) begin
        rem_d = diff[NUM_W-1:0];
      end
      quot_d = {quot_q[CB-2:0], ge};
      dv_d   = dv_q >> 1;
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      rem_d  = num_i;
      dv_d   = DV_W'(den_i) << (CB - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(CB);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_q |=> busy_q)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with no steps left");

endmodule

### design/pwm_period_and_duty_setup_core.sv
// Top level of the PWM period and duty setup engine: command sequencer and timer state.
// Stop and unknown commands answer in the cycle after acceptance, as does a duty command
// on an invalid channel or an unconfigured timer; otherwise a duty command passes ST_CH
// and, when a compare value is computed, ST_MUL and a compare divide. A start command
// tries up to 5 prescalers in turn, one divide for the top, then up to two compare divides.
// One item at a time on the shared divider; busy, if raised, falls with the result strobe.
// Reset clears all timer state and loads the clock register with 16 MHz; results cannot stall.
module pwm_period_and_duty_setup_core #(
  parameter int unsigned COUNTER_BITS = pwmsetup_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic [pwmsetup_pkg::CMD_W-1:0]      command_i,
  input  logic [pwmsetup_pkg::FREQ_W-1:0]     freq_q8_i,
  input  logic [pwmsetup_pkg::CH_W-1:0]       channel_i,
  input  logic signed [pwmsetup_pkg::DUTY_W-1:0] duty_q8_i,
  // Configuration channel: timer input clock in hertz.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pwmsetup_pkg::CLK_W-1:0]      cfg_data_i,
  // Result, valid for the one cycle that done_o is high.
  output logic                                done_o,
  output logic                                ok_o,
  output logic [pwmsetup_pkg::OUT_W-1:0]      period_top_o,
  output logic [pwmsetup_pkg::CODE_W-1:0]     prescale_code_o,
  output logic [pwmsetup_pkg::OUT_W-1:0]      compare_a_o,
  output logic [pwmsetup_pkg::OUT_W-1:0]      compare_b_o,
  output logic                                pwm_enable_a_o,
  output logic                                pwm_enable_b_o,
  output logic                                forced_level_a_o,
  output logic                                forced_level_b_o
);

  import pwmsetup_pkg::*;

  localparam int unsigned CB     = COUNTER_BITS;
  localparam int unsigned LIM_W  = D_W + CB;
  localparam int unsigned PROD_W = SDUTY_W + CB;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TRY    = 3'd1;
  localparam logic [2:0] ST_TOPDIV = 3'd2;
  localparam logic [2:0] ST_CH     = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_CMPDIV = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CLK_W-1:0]   clock_q, clock_d;
  logic [CB-1:0]      top_q, top_d;
  logic [CODE_W-1:0]  presc_q, presc_d;
  logic [SDUTY_W-1:0] sduty_q [2];
  logic [SDUTY_W-1:0] sduty_d [2];
  logic               configured_q, configured_d;
  logic [CB-1:0]      cmp_q [2];
  logic [CB-1:0]      cmp_d [2];
  logic [1:0]         en_q, en_d;
  logic [1:0]         lvl_q, lvl_d;
  logic               done_q, done_d;
  logic               ok_q, ok_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               ch_q, ch_d;
  logic               both_q, both_d;

  // Payload registers.
  logic [FREQ_W-1:0]  freq_q, freq_d;
  logic [PROD_W-1:0]  prod_q, prod_d;

  logic               accept;
  logic [SDUTY_W-1:0] duty_clamped;
  logic [N_W-1:0]     n_val;
  logic [D_W-1:0]     d_val;
  logic               fit;
  logic [SDUTY_W-1:0] duty_sel;
  logic [CB-1:0]      cmp_raw;

  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [CB-1:0]      div_quot;

  assign accept      = start && !busy;
  assign busy        = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  // Negative duty reads as zero percent, anything above 100 percent as 100 percent.
  always_comb begin
    if (duty_q8_i[DUTY_W-1]) begin
      duty_clamped = '0;
    end else if (duty_q8_i[DUTY_W-2:0] > DUTY_FULL) begin
      duty_clamped = DUTY_FULL;
    end else begin
      duty_clamped = duty_q8_i[DUTY_W-2:0];
    end
  end

  // With N = clock * 256 and D = prescale * freq, the prescaler fits when
  // D < N <= D * 2^COUNTER_BITS. A zero frequency or clock never fits.
  assign n_val = {clock_q, 8'd0};
  assign d_val = D_W'(freq_q) << presc_shift(idx_q);
  assign fit   = (D_W'(n_val) > d_val) && (LIM_W'(n_val) <= (LIM_W'(d_val) << CB));

  assign duty_sel = sduty_q[ch_q];
  assign cmp_raw  = (div_quot > top_q) ? top_q : div_quot;

  // The divider computes either the rounded top, (2N - D) / (2D), or the rounded
  // compare value, (2 * duty * top + 25600) / 51200.
  always_comb begin
    div_start = 1'b0;
    div_num   = (NUM_W'(n_val) << 1) - NUM_W'(d_val);
    div_den   = DEN_W'(d_val) << 1;
    if (state_q == ST_TRY) begin
      div_start = fit;
    end else if (state_q == ST_MUL) begin
      div_start = 1'b1;
      div_num   = (NUM_W'(prod_q) << 1) + ROUND_HALF;
      div_den   = CMP_DEN;
    end
  end

  pwmsetup_div #(
    .CB    (CB),
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    clock_d      = clock_q;
    top_d        = top_q;
    presc_d      = presc_q;
    sduty_d      = sduty_q;
    configured_d = configured_q;
    cmp_d        = cmp_q;
    en_d         = en_q;
    lvl_d        = lvl_q;
    done_d       = 1'b0;
    ok_d         = ok_q;
    idx_d        = idx_q;
    ch_d         = ch_q;
    both_d       = both_q;
    freq_d       = freq_q;
    prod_d       = prod_q;

    if (cfg_valid_i && cfg_ready_o) begin
      clock_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_START: begin
              freq_d  = freq_q8_i;
              idx_d   = '0;
              state_d = ST_TRY;
            end
            CMD_DUTY: begin
              if (channel_i[1]) begin
                ok_d   = 1'b0;
                done_d = 1'b1;
              end else begin
                sduty_d[channel_i[0]] = duty_clamped;
                ch_d   = channel_i[0];
                both_d = 1'b0;
                if (configured_q && top_q != '0) begin
                  state_d = ST_CH;
                end else begin
                  ok_d   = 1'b1;
                  done_d = 1'b1;
                end
              end
            end
            CMD_STOP: begin
              top_d        = '0;
              presc_d      = '0;
              sduty_d[0]   = '0;
              sduty_d[1]   = '0;
              configured_d = 1'b0;
              cmp_d[0]     = '0;
              cmp_d[1]     = '0;
              en_d         = '0;
              lvl_d        = '0;
              ok_d         = 1'b1;
              done_d       = 1'b1;
            end
            default: begin
              ok_d   = 1'b0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_TRY: begin
        if (fit) begin
          state_d = ST_TOPDIV;
        end else if (idx_q == PRESC_LAST) begin
          ok_d    = 1'b0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_TOPDIV: begin
        if (div_done) begin
          if (div_quot == '0) begin
            // Rounded top of zero: the start fails and nothing changes.
            ok_d    = 1'b0;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            top_d        = div_quot;
            presc_d      = CODE_W'(idx_q) + CODE_W'(1);
            configured_d = 1'b1;
            ch_d         = 1'b0;
            both_d       = 1'b1;
            state_d      = ST_CH;
          end
        end
      end
      ST_CH: begin
        if (duty_sel == '0) begin
          cmp_d[ch_q] = '0;
          en_d[ch_q]  = 1'b0;
          lvl_d[ch_q] = 1'b0;
        end else if (duty_sel >= DUTY_FULL) begin
          cmp_d[ch_q] = top_q;
          en_d[ch_q]  = 1'b0;
          lvl_d[ch_q] = 1'b1;
        end else begin
          prod_d  = PROD_W'(duty_sel) * PROD_W'(top_q);
          state_d = ST_MUL;
        end
        if (duty_sel == '0 || duty_sel >= DUTY_FULL) begin
          if (both_q && !ch_q) begin
            ch_d = 1'b1;
          end else begin
            ok_d    = 1'b1;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_CMPDIV;
      end
      ST_CMPDIV: begin
        if (div_done) begin
          cmp_d[ch_q] = cmp_raw;
          en_d[ch_q]  = 1'b1;
          if (both_q && !ch_q) begin
            ch_d    = 1'b1;
            state_d = ST_CH;
          end else begin
            ok_d    = 1'b1;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      clock_q      <= CLOCK_RESET;
      top_q        <= '0;
      presc_q      <= '0;
      sduty_q[0]   <= '0;
      sduty_q[1]   <= '0;
      configured_q <= 1'b0;
      cmp_q[0]     <= '0;
      cmp_q[1]     <= '0;
      en_q         <= '0;
      lvl_q        <= '0;
      done_q       <= 1'b0;
      ok_q         <= 1'b0;
      idx_q        <= '0;
      ch_q         <= 1'b0;
      both_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clock_q      <= clock_d;
      top_q        <= top_d;
      presc_q      <= presc_d;
      sduty_q      <= sduty_d;
      configured_q <= configured_d;
      cmp_q        <= cmp_d;
      en_q         <= en_d;
      lvl_q        <= lvl_d;
      done_q       <= done_d;
      ok_q         <= ok_d;
      idx_q        <= idx_d;
      ch_q         <= ch_d;
      both_q       <= both_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q <= freq_d;
    prod_q <= prod_d;
  end

  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign period_top_o     = OUT_W'(top_q);
  assign prescale_code_o  = presc_q;
  assign compare_a_o      = OUT_W'(cmp_q[0]);
  assign compare_b_o      = OUT_W'(cmp_q[1]);
  assign pwm_enable_a_o   = en_q[0];
  assign pwm_enable_b_o   = en_q[1];
  assign forced_level_a_o = lvl_q[0];
  assign forced_level_b_o = lvl_q[1];

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result reported while the sequencer is still busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == CMD_START |=> busy)
    else $error("start command did not occupy the sequencer");
  a_configured_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    configured_q |-> top_q != '0 && presc_q != '0)
    else $error("timer configured without a top or prescaler");
  a_compare_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && en_q[0] |-> cmp_q[0] <= top_q)
    else $error("channel 0 compare beyond top");

endmodule

### bench/tb.sv
// Self-checking testbench of the PWM period and duty setup engine.
`timescale 1ns / 100ps

module tb;
  import pwmsetup_pkg::*;

  // Command 3 has no meaning to the engine and must be refused.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  localparam int unsigned CNT_BITS  = COUNTER_BITS_DEF;
  localparam logic [63:0] TOP_LIMIT = (64'd1 << CNT_BITS) - 64'd1;
  // Prescalers 1, 8, 64, 256 and 1024 as left shifts, in the order they are tried.
  localparam int PRESC_LOG2 [5] = '{0, 3, 6, 8, 10};
  localparam logic [15:0] DUTY_HUNDRED = 16'd25600;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 3 * CNT_BITS + 20;
  localparam int MAX_REPORTS  = 20;

  // One result of the engine: the timer state after the command.
  typedef struct packed {
    logic              ok;
    logic [OUT_W-1:0]  top;
    logic [CODE_W-1:0] code;
    logic [OUT_W-1:0]  cmp_a;
    logic [OUT_W-1:0]  cmp_b;
    logic              en_a;
    logic              en_b;
    logic              lvl_a;
    logic              lvl_b;
  } setup_t;

  // One row of the directed table: either a command item or a clock register write.
  typedef struct {
    bit                is_cfg;
    bit                typed;
    logic [CMD_W-1:0]  cmd;
    logic [FREQ_W-1:0] freq;
    logic [CH_W-1:0]   ch;
    logic [DUTY_W-1:0] duty;
    logic [CLK_W-1:0]  clock;
    setup_t            want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         command_i = '0;
  logic [FREQ_W-1:0]        freq_q8_i = '0;
  logic [CH_W-1:0]          channel_i = '0;
  logic signed [DUTY_W-1:0] duty_q8_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CLK_W-1:0]         cfg_data_i = '0;
  logic                     done_o;
  logic                     ok_o;
  logic [OUT_W-1:0]         period_top_o;
  logic [CODE_W-1:0]        prescale_code_o;
  logic [OUT_W-1:0]         compare_a_o;
  logic [OUT_W-1:0]         compare_b_o;
  logic                     pwm_enable_a_o;
  logic                     pwm_enable_b_o;
  logic                     forced_level_a_o;
  logic                     forced_level_b_o;

  pwm_period_and_duty_setup_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .freq_q8_i        (freq_q8_i),
    .channel_i        (channel_i),
    .duty_q8_i        (duty_q8_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .ok_o             (ok_o),
    .period_top_o     (period_top_o),
    .prescale_code_o  (prescale_code_o),
    .compare_a_o      (compare_a_o),
    .compare_b_o      (compare_b_o),
    .pwm_enable_a_o   (pwm_enable_a_o),
    .pwm_enable_b_o   (pwm_enable_b_o),
    .forced_level_a_o (forced_level_a_o),
    .forced_level_b_o (forced_level_b_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Timer state as the engine should hold it, with its own copy of the clock register.
  logic [CLK_W-1:0]   model_clock = CLK_W'(16000000);
  logic [OUT_W-1:0]   model_top;
  logic [CODE_W-1:0]  model_code;
  logic [SDUTY_W-1:0] model_duty [2];
  logic               model_armed;
  logic [OUT_W-1:0]   model_cmp [2];
  logic               model_en [2];
  logic               model_lvl [2];

  setup_t    pending_setups [$];
  stim_row_t directed_rows [$];

  int mismatches = 0;
  int results_checked = 0;
  int items_sent = 0;
  int starts_ok = 0;
  int starts_refused = 0;
  int duties_applied = 0;
  int stops_done = 0;
  int clock_writes = 0;
  int burst_left = 0;

  // Stop clears the whole timer state but leaves the clock register alone.
  function automatic void clear_timer_model();
    model_top   = '0;
    model_code  = '0;
    model_armed = 1'b0;
    for (int i = 0; i < 2; i++) begin
      model_duty[i] = '0;
      model_cmp[i]  = '0;
      model_en[i]   = 1'b0;
      model_lvl[i]  = 1'b0;
    end
  endfunction

  // Puts one channel on the given duty against the given top. At 0 percent the pin is
  // held low, at 100 percent it is held high with compare at top; in between the compare
  // unit drives it and the static level is left as it was.
  function automatic void drive_channel_model(int ch, logic [SDUTY_W-1:0] duty,
                                              logic [OUT_W-1:0] top);
    logic [63:0] scaled;
    if (duty == '0) begin
      model_en[ch]  = 1'b0;
      model_cmp[ch] = '0;
      model_lvl[ch] = 1'b0;
    end else if (16'(duty) >= DUTY_HUNDRED) begin
      model_en[ch]  = 1'b0;
      model_cmp[ch] = top;
      model_lvl[ch] = 1'b1;
    end else begin
      // Exact rational percent * top / 100 rounded half up, then capped at top.
      scaled = (64'd2 * 64'(duty) * 64'(top) + 64'd25600) / 64'd51200;
      if (scaled > 64'(top))
        scaled = 64'(top);
      model_cmp[ch] = OUT_W'(scaled);
      model_en[ch]  = 1'b1;
    end
  endfunction

  // Applies one command item to the timer state and returns the result it must produce.
  function automatic setup_t timer_setup_after(logic [CMD_W-1:0] cmd, logic [FREQ_W-1:0] freq,
                                               logic [CH_W-1:0] ch, logic [DUTY_W-1:0] raw);
    setup_t             res;
    logic               ok;
    logic               found;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        top64;
    logic [CODE_W-1:0]  code;
    logic [SDUTY_W-1:0] duty;
    ok    = 1'b0;
    found = 1'b0;
    top64 = '0;
    code  = '0;
    case (cmd)
      CMD_START: begin
        // With N = clock * 256 and D = prescale * freq_q8 the top is N / D - 1; the first
        // prescaler that puts it in (0, max] is taken, and a top that rounds to zero fails.
        if (freq != '0) begin
          num = 64'(model_clock) << 8;
          for (int i = 0; i < 5; i++) begin
            den = 64'(freq) << PRESC_LOG2[i];
            if (!found && num > den && num <= (den << CNT_BITS)) begin
              found = 1'b1;
              top64 = (64'd2 * num - den) / (64'd2 * den);
              code  = CODE_W'(i + 1);
            end
          end
          if (found && top64 != '0 && top64 <= TOP_LIMIT) begin
            drive_channel_model(0, model_duty[0], OUT_W'(top64));
            drive_channel_model(1, model_duty[1], OUT_W'(top64));
            model_top   = OUT_W'(top64);
            model_code  = code;
            model_armed = 1'b1;
            ok          = 1'b1;
          end
        end
      end
      CMD_DUTY: begin
        if (ch <= 2'd1) begin
          // Negative percent clamps to zero, anything past 100 percent to 100.
          if (raw[DUTY_W-1])
            duty = '0;
          else if (raw > DUTY_HUNDRED)
            duty = SDUTY_W'(DUTY_HUNDRED);
          else
            duty = raw[SDUTY_W-1:0];
          model_duty[ch] = duty;
          // Before a successful start the duty is only remembered.
          if (model_armed && model_top != '0)
            drive_channel_model(int'(ch), duty, model_top);
          ok = 1'b1;
        end
      end
      CMD_STOP: begin
        clear_timer_model();
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    res.ok    = ok;
    res.top   = model_top;
    res.code  = model_code;
    res.cmp_a = model_cmp[0];
    res.cmp_b = model_cmp[1];
    res.en_a  = model_en[0];
    res.en_b  = model_en[1];
    res.lvl_a = model_lvl[0];
    res.lvl_b = model_lvl[1];
    return res;
  endfunction

  // A result with the timer still cleared, as after reset or stop.
  function automatic setup_t cleared_setup(logic ok);
    setup_t res;
    res    = '0;
    res.ok = ok;
    return res;
  endfunction

  function automatic void plan_item(logic [CMD_W-1:0] cmd, logic [FREQ_W-1:0] freq,
                                    logic [CH_W-1:0] ch, logic [DUTY_W-1:0] duty);
    stim_row_t row;
    row        = '{default: '0};
    row.cmd    = cmd;
    row.freq   = freq;
    row.ch     = ch;
    row.duty   = duty;
    directed_rows.push_back(row);
  endfunction

  // A row whose result is written out by hand instead of taken from the predictor.
  function automatic void plan_known(logic [CMD_W-1:0] cmd, logic [FREQ_W-1:0] freq,
                                     logic [CH_W-1:0] ch, logic [DUTY_W-1:0] duty,
                                     setup_t want);
    plan_item(cmd, freq, ch, duty);
    directed_rows[$].typed = 1'b1;
    directed_rows[$].want  = want;
  endfunction

  function automatic void plan_clock(logic [CLK_W-1:0] clock);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.clock  = clock;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Results are sampled at the rising edge that ends the strobe cycle; the engine
  // cannot hold them, so every strobe is taken as it comes.
  always @(posedge clk_i) begin : result_check
    setup_t want;
    if (rst_ni && done_o) begin
      if (pending_setups.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        want = pending_setups.pop_front();
        results_checked++;
        check_field("ok", ok_o, want.ok);
        check_field("period_top", period_top_o, want.top);
        check_field("prescale_code", prescale_code_o, want.code);
        check_field("compare_a", compare_a_o, want.cmp_a);
        check_field("compare_b", compare_b_o, want.cmp_b);
        check_field("pwm_enable_a", pwm_enable_a_o, want.en_a);
        check_field("pwm_enable_b", pwm_enable_b_o, want.en_b);
        check_field("forced_level_a", forced_level_a_o, want.lvl_a);
        check_field("forced_level_b", forced_level_b_o, want.lvl_b);
      end
    end
  end

  // Presents one item and holds it until the engine takes it (start high, busy low at
  // an edge). The expectation is queued at that same edge, ahead of any result strobe.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [FREQ_W-1:0] freq,
                           input logic [CH_W-1:0] ch, input logic [DUTY_W-1:0] duty,
                           input bit typed, input setup_t want);
    setup_t predicted;
    start     <= 1'b1;
    command_i <= cmd;
    freq_q8_i <= freq;
    channel_i <= ch;
    duty_q8_i <= duty;
    do @(posedge clk_i); while (busy);
    predicted = timer_setup_after(cmd, freq, ch, duty);
    pending_setups.push_back(typed ? want : predicted);
    items_sent++;
    case (cmd)
      CMD_START: if (predicted.ok) starts_ok++; else starts_refused++;
      CMD_DUTY:  if (predicted.ok && model_armed) duties_applied++;
      CMD_STOP:  stops_done++;
      default: ;
    endcase
  endtask

  // The sender works in bursts: start stays high across a burst, then drops for a random
  // gap. Some gaps are zero, so long stretches run back to back.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 15);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // The clock register is only written with the engine idle and every result home.
  task automatic write_clock(input logic [CLK_W-1:0] clock);
    start <= 1'b0;
    while (pending_setups.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= clock;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_clock = clock;
    clock_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Random frequency spread over all magnitudes, so that every prescaler gets picked
  // and both ends fail now and then.
  function automatic logic [FREQ_W-1:0] random_freq();
    int unsigned msb;
    if ($urandom_range(0, 19) == 0)
      return '0;
    msb = $urandom_range(0, FREQ_W - 1);
    return FREQ_W'(($urandom & ((32'd1 << msb) - 32'd1)) | (32'd1 << msb));
  endfunction

  // Random duty with weight on the clamp points and on the edges of the open range.
  function automatic logic [DUTY_W-1:0] random_duty();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DUTY_HUNDRED;
      2:       return DUTY_W'($urandom_range(25601, 32767));
      3:       return DUTY_W'(16'h8000 | $urandom_range(0, 16'h7FFF));
      4:       return $urandom_range(0, 1) ? 16'd1 : 16'd25599;
      default: return DUTY_W'($urandom_range(0, 25600));
    endcase
  endfunction

  initial begin : run_limit
    #5_000_000;
    $display("Timeout with %0d results still outstanding", pending_setups.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [CLK_W-1:0]  clock;
    logic [CMD_W-1:0]  cmd;
    int unsigned       pick;

    // The predictor starts from the same cleared timer as the engine after reset.
    clear_timer_model();

    // After reset: refusals and duties before any start leave the timer all zero.
    plan_known(CMD_UNKNOWN, '0, 2'd0, '0, cleared_setup(1'b0));
    plan_known(CMD_DUTY, '0, 2'd0, 16'd12800, cleared_setup(1'b1));
    plan_known(CMD_DUTY, '0, 2'd1, 16'h8000, cleared_setup(1'b1));
    plan_known(CMD_DUTY, '0, 2'd2, 16'd1000, cleared_setup(1'b0));
    plan_known(CMD_DUTY, '0, 2'd3, 16'h7FFF, cleared_setup(1'b0));
    plan_known(CMD_START, '0, 2'd0, '0, cleared_setup(1'b0));
    // 1/256 Hz is too slow for even the largest prescaler.
    plan_known(CMD_START, 28'd1, 2'd0, '0, cleared_setup(1'b0));
    // 1 kHz at 16 MHz, which picks up the stored 50 percent on channel 0.
    plan_item(CMD_START, 28'd256000, 2'd0, '0);
    plan_item(CMD_DUTY, '0, 2'd1, DUTY_HUNDRED);
    plan_item(CMD_DUTY, '0, 2'd0, 16'h7FFF);
    plan_item(CMD_DUTY, '0, 2'd0, 16'd1);
    plan_item(CMD_DUTY, '0, 2'd1, 16'd25599);
    plan_item(CMD_DUTY, '0, 2'd0, 16'd0);
    plan_item(CMD_START, 28'h0FFFFFFF, 2'd0, '0);
    // 0.25 Hz only fits with the divide-by-1024 prescaler.
    plan_item(CMD_START, 28'd64, 2'd0, '0);
    plan_known(CMD_STOP, '0, 2'd0, '0, cleared_setup(1'b1));
    // At 1 Hz, 200/256 Hz fits the first prescaler but its top rounds to zero.
    plan_clock(27'd1);
    plan_known(CMD_START, 28'd200, 2'd0, '0, cleared_setup(1'b0));
    plan_item(CMD_START, 28'd128, 2'd0, '0);
    // With no clock nothing fits and the last good setup stays.
    plan_clock(27'd0);
    plan_item(CMD_START, 28'd256000, 2'd0, '0);
    plan_clock(27'h7FFFFFF);
    plan_item(CMD_START, 28'h0FFFFFFF, 2'd0, '0);
    plan_clock(27'd100000000);
    plan_item(CMD_START, 28'd2560, 2'd0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_clock(directed_rows[i].clock);
      end else begin
        send_item(directed_rows[i].cmd, directed_rows[i].freq, directed_rows[i].ch,
                  directed_rows[i].duty, directed_rows[i].typed, directed_rows[i].want);
        pace_sender();
      end
    end

    // Random phases, each under its own clock setting. Starts and duties dominate so
    // that most of the run sees a configured timer; stops and refusals are mixed in.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       clock = CLK_W'(16000000);
        1:       clock = CLK_W'(1);
        2:       clock = CLK_W'(100000000);
        3:       clock = '1;
        4:       clock = '0;
        5:       clock = CLK_W'($urandom_range(1, 100000000));
        6:       clock = CLK_W'($urandom_range(1000, 20000000));
        default: clock = CLK_W'($urandom);
      endcase
      write_clock(clock);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)
          cmd = CMD_START;
        else if (pick < 88)
          cmd = CMD_DUTY;
        else if (pick < 94)
          cmd = CMD_STOP;
        else
          cmd = CMD_UNKNOWN;
        send_item(cmd, random_freq(),
                  ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(2, 3))
                                              : CH_W'($urandom_range(0, 1)),
                  random_duty(), 1'b0, '0);
        pace_sender();
      end
    end

    start <= 1'b0;
    while (pending_setups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items under %0d clock settings; %0d results checked.",
             items_sent, clock_writes, results_checked);
    $display("Starts taken %0d, refused %0d; duties applied %0d; stops %0d; mismatches %0d.",
             starts_ok, starts_refused, duties_applied, stops_done, mismatches);
    if (mismatches == 0 && pending_setups.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
